// File: rtl/core/deq_pkg.sv
// deq_pkg: request and status codes and controller handshake structs for the deque
`timescale 1ns / 1ps

package deq_pkg;

  // request codes
  localparam logic [1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [1:0] REQ_POP_FRONT  = 2'd2;
  localparam logic [1:0] REQ_POP_BACK   = 2'd3;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // field widths
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 7;

  // commands from the controller to the datapath
  typedef struct packed {
    logic capture;     // latch the incoming request word
    logic exec;        // update pointers, write on push, read popped slot
    logic issue_read;  // read the new front and back slots
    logic load;        // move the finished result into the output register
  } deq_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_busy;    // output register holds a word that is not taken this cycle
  } deq_stat_t;

endpackage

// File: rtl/core/deq_req_if.sv
// deq_req_if: request channel of the deque
`timescale 1ns / 1ps

interface deq_req_if;
  import deq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [1:0]                req_type;
  logic signed [VALUE_W-1:0] data_value;

  modport source (output valid, output req_type, output data_value, input ready);
  modport sink (input valid, input req_type, input data_value, output ready);
endinterface

// File: rtl/core/deq_rsp_if.sv
// deq_rsp_if: result channel of the deque
`timescale 1ns / 1ps

interface deq_rsp_if;
  import deq_pkg::*;

  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] popped_value;
  logic [1:0]                op_status;
  logic [COUNT_W-1:0]        entry_count;
  logic                      is_empty;
  logic signed [VALUE_W-1:0] front_value;
  logic signed [VALUE_W-1:0] back_value;

  modport source (
    output valid, output popped_value, output op_status, output entry_count,
    output is_empty, output front_value, output back_value, input ready
  );
  modport sink (
    input valid, input popped_value, input op_status, input entry_count,
    input is_empty, input front_value, input back_value, output ready
  );
endinterface

// File: rtl/core/deq_ctrl.sv
// deq_ctrl: sequencing state machine for one deque request
`timescale 1ns / 1ps

module deq_ctrl
  import deq_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  output logic      req_ready,
  output deq_cmd_t  cmd,
  input  deq_stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_EXEC = 4'b0010,
    S_READ = 4'b0100,
    S_LOAD = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next     = state;
    cmd            = '0;
    req_ready      = 1'b0;
    case (state)
      S_IDLE: begin
        // no request word is taken while reset is held
        req_ready   = !rst;
        cmd.capture = req_valid && !rst;
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.issue_read = 1'b1;
        state_next     = S_LOAD;
      end
      S_LOAD: begin
        // wait here while the previous result is still unclaimed
        if (!stat.out_busy) begin
          cmd.load   = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// File: rtl/core/deq_datapath.sv
// deq_datapath: ring buffer storage, pointers and result register of the deque
`timescale 1ns / 1ps

module deq_datapath
  import deq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input  logic                      clk,
  input  logic                      rst,
  input  deq_cmd_t                  cmd,
  output deq_stat_t                 stat,
  input  logic [1:0]                req_type,
  input  logic signed [VALUE_W-1:0] data_value,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic signed [VALUE_W-1:0] popped_value,
  output logic [1:0]                op_status,
  output logic [COUNT_W-1:0]        entry_count,
  output logic                      is_empty,
  output logic signed [VALUE_W-1:0] front_value,
  output logic signed [VALUE_W-1:0] back_value
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;

  logic [VALUE_W-1:0] mem [DEPTH];

  logic [1:0]         req_q;
  logic [VALUE_W-1:0] data_q;
  logic [PTR_W-1:0]   head;
  logic [CNT_W-1:0]   occ;
  logic [1:0]         status_q;
  logic               pop_ok_q;
  logic [VALUE_W-1:0] popped_q;
  logic [VALUE_W-1:0] rd_a;
  logic [VALUE_W-1:0] rd_b;

  logic               is_push;
  logic               is_front;
  logic               full;
  logic               empty;
  logic [PTR_W-1:0]   head_dec;
  logic [PTR_W-1:0]   head_inc;
  logic [SUM_W-1:0]   tail_sum;
  logic [SUM_W-1:0]   tail_wrap;
  logic [SUM_W-1:0]   back_sum;
  logic [SUM_W-1:0]   back_wrap;
  logic [PTR_W-1:0]   tail_idx;
  logic [PTR_W-1:0]   back_idx;
  logic               mem_we;
  logic [PTR_W-1:0]   waddr;
  logic               ren_a;
  logic [PTR_W-1:0]   raddr_a;
  logic [CNT_W+COUNT_W-1:0] occ_ext;

  // request decode and ring index arithmetic
  always_comb begin
    is_push   = (req_q == REQ_PUSH_FRONT) || (req_q == REQ_PUSH_BACK);
    is_front  = (req_q == REQ_PUSH_FRONT) || (req_q == REQ_POP_FRONT);
    full      = (occ == CNT_W'(DEPTH));
    empty     = (occ == '0);
    head_dec  = (head == '0) ? PTR_W'(DEPTH - 1) : head - 1'b1;
    head_inc  = (head == PTR_W'(DEPTH - 1)) ? '0 : head + 1'b1;
    tail_sum  = SUM_W'(head) + SUM_W'(occ);
    tail_wrap = (tail_sum >= SUM_W'(DEPTH)) ? tail_sum - SUM_W'(DEPTH) : tail_sum;
    back_sum  = tail_sum - 1'b1;
    back_wrap = (back_sum >= SUM_W'(DEPTH)) ? back_sum - SUM_W'(DEPTH) : back_sum;
    tail_idx  = tail_wrap[PTR_W-1:0];
    back_idx  = back_wrap[PTR_W-1:0];
  end

  // memory port control
  always_comb begin
    mem_we  = cmd.exec && is_push && !full;
    waddr   = is_front ? head_dec : tail_idx;
    ren_a   = (cmd.exec && !is_push && !empty) || cmd.issue_read;
    raddr_a = (cmd.exec && !is_front) ? back_idx : head;
  end

  // ring storage with registered reads
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[waddr] <= data_q;
    end
    if (ren_a) begin
      rd_a <= mem[raddr_a];
    end
    if (cmd.issue_read) begin
      rd_b <= mem[back_idx];
    end
  end

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_q  <= req_type;
      data_q <= data_value;
    end
  end

  // pointer and count update
  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      occ  <= '0;
    end else if (cmd.exec) begin
      if (is_push && !full) begin
        occ <= occ + 1'b1;
        if (is_front) begin
          head <= head_dec;
        end
      end else if (!is_push && !empty) begin
        occ <= occ - 1'b1;
        if (is_front) begin
          head <= head_inc;
        end
      end
    end
  end

  // status and popped value
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pop_ok_q <= !is_push && !empty;
      if (is_push) begin
        status_q <= full ? ST_FULL : ST_DONE;
      end else begin
        status_q <= empty ? ST_EMPTY : ST_DONE;
      end
    end
    if (cmd.issue_read) begin
      popped_q <= pop_ok_q ? rd_a : '0;
    end
  end

  assign occ_ext = {{COUNT_W{1'b0}}, occ};

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      popped_value <= popped_q;
      op_status    <= status_q;
      entry_count  <= occ_ext[COUNT_W-1:0];
      is_empty     <= empty;
      front_value  <= empty ? '0 : rd_a;
      back_value   <= empty ? '0 : rd_b;
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign stat.out_busy = out_valid && !out_ready;

  // count stays within the ring
  a_occ_range: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(DEPTH))
    else $error("deque occupancy above depth");

  // head pointer stays within the ring
  a_head_range: assert property (@(posedge clk) disable iff (rst)
    head <= PTR_W'(DEPTH - 1))
    else $error("deque head pointer out of range");

  // an accepted push grows the count by one
  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    (cmd.exec && is_push && !full) |=> (occ == $past(occ) + 1'b1))
    else $error("push did not grow the count");

  // a result is never loaded over one that is still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load |-> !(out_valid && !out_ready))
    else $error("result register overwritten");

endmodule

// File: rtl/core/double_ended_queue.sv
// double_ended_queue: bounded deque of signed words over a ring buffer
// a result word passes through the update, read and load steps after its request is accepted
// a new request is taken only back in idle, after the sequencer has walked the
//   single-write, dual-read ring memory through update, read and load steps
// a new request is taken while the previous result still waits in the output register
// reset (rst, synchronous) empties the queue and clears the head pointer; no clearing pass
`timescale 1ns / 1ps

module double_ended_queue
  import deq_pkg::*;
#(
  parameter int DEPTH = 64
) (
  input logic   clk,
  input logic   rst,
  deq_req_if.sink   req,
  deq_rsp_if.source rsp
);

  deq_cmd_t  cmd;
  deq_stat_t stat;

  // sequencer
  deq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // storage and result path
  deq_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .stat         (stat),
    .req_type     (req.req_type),
    .data_value   (req.data_value),
    .out_valid    (rsp.valid),
    .out_ready    (rsp.ready),
    .popped_value (rsp.popped_value),
    .op_status    (rsp.op_status),
    .entry_count  (rsp.entry_count),
    .is_empty     (rsp.is_empty),
    .front_value  (rsp.front_value),
    .back_value   (rsp.back_value)
  );

endmodule
